[rtl/core/pira_pkg.sv]
// Package for the positional insert/remove array: request and status codes,
// cell commands and beat field widths. No dependencies.
`default_nettype none

package pira_pkg;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned S_DATA_W = 40;  // position + element_in, padded to bytes
  localparam int unsigned M_DATA_W = 40;  // element_count + element_out, padded

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH     = 3'd0,
    FUNC_POP      = 3'd1,
    FUNC_INSERT   = 3'd2,
    FUNC_REMOVE   = 3'd3,
    FUNC_INS_MID  = 3'd4,
    FUNC_REM_MID  = 3'd5,
    FUNC_READ     = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e          op;
    logic [ELEM_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/pira_cell.sv]
// One storage cell of the array chain: holds, loads, or takes its left or
// right neighbor's element. Depends on pira_pkg.
`default_nettype none

module pira_cell #(
  parameter int unsigned IW    = 4,
  parameter int unsigned INDEX = 0
) (
  input  wire                          clk_i,
  input  pira_pkg::cell_cmd_t          cmd_i,
  input  wire [IW-1:0]                 idx_i,
  input  wire [pira_pkg::ELEM_W-1:0]   left_i,
  input  wire [pira_pkg::ELEM_W-1:0]   right_i,
  output logic [pira_pkg::ELEM_W-1:0]  data_o
);
  import pira_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [ELEM_W-1:0] data_q, data_d;

  // Pick the next element: shift up past the insert point, shift down from it
  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (MY_IDX > idx_i) begin
          data_d = left_i;
        end else if (MY_IDX == idx_i) begin
          data_d = cmd_i.value;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= idx_i) begin
          data_d = right_i;
        end
      end
      CELL_HOLD: begin
        data_d = data_q;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/core/pira_chain.sv]
// Row of DEPTH cells wired neighbor to neighbor, plus the read select.
// Depends on pira_pkg and pira_cell.
`default_nettype none

module pira_chain #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  wire                          clk_i,
  input  pira_pkg::cell_cmd_t          cmd_i,
  input  wire [IW-1:0]                 idx_i,
  input  wire [IW-1:0]                 rd_idx_i,
  output logic [pira_pkg::ELEM_W-1:0]  rd_data_o
);
  import pira_pkg::*;

  logic [ELEM_W-1:0] cell_q [DEPTH];

  // Build the row; the first cell never takes its left zero, but the last cell takes its right zero on a remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    pira_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .idx_i   (idx_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_q[i])
    );
  end

  // Select the element for a read request
  assign rd_data_o = cell_q[rd_idx_i];

endmodule

`default_nettype wire

[rtl/core/positional_insert_remove_array_core.sv]
// Top level of the positional insert/remove array: request decode, fill count
// and result register around the cell chain. Depends on pira_pkg, pira_chain.
//
//  channel | dir | tdata (low bit up)                  | tuser
//  --------+-----+-------------------------------------+-------------
//  s_axis  | in  | position[4:0], element_in[36:5]     | func[2:0]
//  m_axis  | out | element_count[4:0], element_out[36:5]| status[1:0]
//
// One request per cycle: every cell shifts at once, so an insert, remove or
// read finishes in the cycle it is accepted and its result beat appears in
// the result register on the next cycle.
// Reset clears the fill count and the result valid; cell contents are not
// cleared. A stalled result beat holds; a new request is taken whenever the
// result register is empty or is being drained in the same cycle.
`default_nettype none

module positional_insert_remove_array_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [pira_pkg::S_DATA_W-1:0]   s_axis_tdata,   // position, element_in
  input  wire [pira_pkg::FUNC_W-1:0]     s_axis_tuser,   // func
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [pira_pkg::M_DATA_W-1:0]  m_axis_tdata,   // element_count, element_out
  output logic [pira_pkg::STATUS_W-1:0]  m_axis_tuser    // status
);
  import pira_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [COUNT_W-1:0] out_count_q;
  logic [ELEM_W-1:0] out_elem_q, elem_d;

  logic              accept;
  func_e             func;
  logic [PW-1:0]     pos_w, cnt_w, half_w, idx_w, cnt_next_w;
  logic              full, empty, rd_hit;
  cell_cmd_t         cmd;
  logic [ELEM_W-1:0] rd_data;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign func   = func_e'(s_axis_tuser);
  assign pos_w  = PW'(s_axis_tdata[POS_W-1:0]);
  assign cnt_w  = PW'(count_q);
  assign half_w = cnt_w >> 1;
  assign full   = (cnt_w == DEPTH_W);
  assign empty  = (count_q == '0);

  // Decode the request into a cell command, new count and status
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.value = s_axis_tdata[POS_W +: ELEM_W];
    idx_w     = pos_w;
    count_d   = count_q;
    status_d  = ST_OK;
    rd_hit    = 1'b0;
    unique case (func)
      FUNC_PUSH: begin
        idx_w = cnt_w;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + CW'(1);
        end
      end
      FUNC_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      FUNC_INSERT: begin
        if (pos_w > cnt_w) begin
          status_d = ST_INDEX;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + CW'(1);
        end
      end
      FUNC_REMOVE: begin
        if (pos_w >= cnt_w) begin
          status_d = ST_INDEX;
        end else begin
          cmd.op  = CELL_REMOVE;
          count_d = count_q - CW'(1);
        end
      end
      FUNC_INS_MID: begin
        idx_w = half_w;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + CW'(1);
        end
      end
      FUNC_REM_MID: begin
        idx_w = half_w;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.op  = CELL_REMOVE;
          count_d = count_q - CW'(1);
        end
      end
      FUNC_READ: begin
        if (pos_w < cnt_w) begin
          rd_hit = 1'b1;
        end else begin
          status_d = ST_INDEX;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    if (!accept) begin
      cmd.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  assign elem_d     = rd_hit ? rd_data : '0;
  assign cnt_next_w = PW'(count_d);

  pira_chain #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .idx_i     (idx_w[IW-1:0]),
    .rd_idx_i  (pos_w[IW-1:0]),
    .rd_data_o (rd_data)
  );

  // Hold the fill count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result beat on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_count_q <= cnt_next_w[COUNT_W-1:0];
      out_elem_q  <= elem_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{(M_DATA_W - COUNT_W - ELEM_W){1'b0}}, out_elem_q, out_count_q};

endmodule

`default_nettype wire

[rtl/core/pira_checker.sv]
// Port-level checks for positional_insert_remove_array_core, bound to the
// top level. Depends on pira_pkg.
`default_nettype none

module pira_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  input  wire                            s_axis_tready,
  input  wire [pira_pkg::S_DATA_W-1:0]   s_axis_tdata,   // position, element_in
  input  wire [pira_pkg::FUNC_W-1:0]     s_axis_tuser,   // func
  input  wire                            m_axis_tvalid,
  input  wire                            m_axis_tready,
  input  wire [pira_pkg::M_DATA_W-1:0]   m_axis_tdata,   // element_count, element_out
  input  wire [pira_pkg::STATUS_W-1:0]   m_axis_tuser    // status
);
  import pira_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // Take a request whenever no result is waiting
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // Report full only with the array at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
      m_axis_tdata[COUNT_W-1:0] == DEPTH_C)
    else $error("full status with count below capacity");

  // Report empty only with no elements
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
      m_axis_tdata[COUNT_W-1:0] == '0)
    else $error("empty status with nonzero count");

  // Drive zero element data on any failed request
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |->
      m_axis_tdata[COUNT_W +: ELEM_W] == '0)
    else $error("element data on failed request");

endmodule

bind positional_insert_remove_array_core pira_checker #(.DEPTH(DEPTH)) u_pira_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for positional_insert_remove_array_core: a directed table
// plus biased random requests, checked beat by beat against a shadow array or a hand-written expectation.
// Depends on pira_pkg and the core RTL.
`default_nettype none

module tb_top;
  import pira_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned N_RANDOM    = 1330;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } mix_mode_e;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic [ELEM_W-1:0]  elem;
  } array_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
    logic              typed;
    array_result_t     want;
  } req_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;   // position, element_in
  logic [FUNC_W-1:0]   s_axis_tuser;   // func
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;   // element_count, element_out
  logic [STATUS_W-1:0] m_axis_tuser;   // status

  // Shadow copy of the array
  logic [ELEM_W-1:0] shadow_cells [DEPTH];
  int unsigned       shadow_count;

  array_result_t pending_results [$];

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_bad_index;
  int unsigned cycle_cnt;
  bit          no_idle;
  bit          rx_long_hold_req;

  // Directed requests; rows with typed set carry a hand-written expectation
  req_row_t directed_tbl [0:22] = '{
    '{FUNC_READ,    5'd0,  32'h0000_0000, 1'b1, '{ST_INDEX, 5'd0, 32'h0}},
    '{FUNC_POP,     5'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY, 5'd0, 32'h0}},
    '{FUNC_REM_MID, 5'd0,  32'h0000_0000, 1'b1, '{ST_EMPTY, 5'd0, 32'h0}},
    '{FUNC_REMOVE,  5'd0,  32'h0000_0000, 1'b1, '{ST_INDEX, 5'd0, 32'h0}},
    '{FUNC_INSERT,  5'd1,  32'h0000_0005, 1'b1, '{ST_INDEX, 5'd0, 32'h0}},
    '{FUNC_UNUSED,  5'd0,  32'h0000_0000, 1'b1, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_PUSH,    5'd0,  32'h7FFF_FFFF, 1'b1, '{ST_OK,    5'd1, 32'h0}},
    '{FUNC_PUSH,    5'd31, 32'h8000_0000, 1'b1, '{ST_OK,    5'd2, 32'h0}},
    '{FUNC_READ,    5'd1,  32'h0000_0000, 1'b1, '{ST_OK,    5'd2, 32'h8000_0000}},
    '{FUNC_INSERT,  5'd0,  32'hFFFF_FFFF, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_INSERT,  5'd3,  32'h0000_0001, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_INS_MID, 5'd17, 32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_READ,    5'd31, 32'hFFFF_FFFF, 1'b1, '{ST_INDEX, 5'd5, 32'h0}},
    '{FUNC_READ,    5'd4,  32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_READ,    5'd2,  32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_REMOVE,  5'd5,  32'h0000_0000, 1'b1, '{ST_INDEX, 5'd5, 32'h0}},
    '{FUNC_REMOVE,  5'd0,  32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_REM_MID, 5'd31, 32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_INSERT,  5'd31, 32'h1234_5678, 1'b1, '{ST_INDEX, 5'd3, 32'h0}},
    '{FUNC_POP,     5'd0,  32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_UNUSED,  5'd31, 32'hFFFF_FFFF, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_READ,    5'd0,  32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}},
    '{FUNC_REMOVE,  5'd1,  32'h0000_0000, 1'b0, '{ST_OK,    5'd0, 32'h0}}
  };

  positional_insert_remove_array_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Open a slot at idx and store val, shifting later cells up
  function automatic status_e shadow_insert(input int unsigned idx, input logic [ELEM_W-1:0] val);
    if (idx > shadow_count) return ST_INDEX;
    if (shadow_count >= DEPTH) return ST_FULL;
    for (int unsigned i = shadow_count; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[idx] = val;
    shadow_count++;
    return ST_OK;
  endfunction

  // Close the slot at idx, shifting later cells down
  function automatic status_e shadow_remove(input int unsigned idx);
    if (idx >= shadow_count) return ST_INDEX;
    for (int unsigned i = idx; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
    shadow_count--;
    return ST_OK;
  endfunction

  // Apply one request to the shadow array and return the result beat it yields
  function automatic array_result_t apply_array_op(input logic [FUNC_W-1:0] f,
                                                   input logic [POS_W-1:0] p,
                                                   input logic [ELEM_W-1:0] v);
    array_result_t r;
    r.status = ST_OK;
    r.elem   = '0;
    case (f)
      FUNC_PUSH:    r.status = shadow_insert(shadow_count, v);
      FUNC_POP: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      FUNC_INSERT:  r.status = shadow_insert(p, v);
      FUNC_REMOVE:  r.status = shadow_remove(p);
      FUNC_INS_MID: r.status = shadow_insert(shadow_count / 2, v);
      FUNC_REM_MID: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.status = shadow_remove(shadow_count / 2);
      end
      FUNC_READ: begin
        if (p < shadow_count) r.elem = shadow_cells[p];
        else r.status = ST_INDEX;
      end
      default: ;
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  // Offer one request beat, wait for acceptance, then record what it must yield
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                              input logic [ELEM_W-1:0] v, input logic typed,
                              input array_result_t want);
    int unsigned   gap;
    array_result_t predicted;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_DATA_W-ELEM_W-POS_W){1'b0}}, v, p};
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_array_op(f, p, v);
    pending_results.push_back(typed ? want : predicted);
    n_sent++;
    if (predicted.status == ST_FULL)  n_full++;
    if (predicted.status == ST_EMPTY) n_empty++;
    if (predicted.status == ST_INDEX) n_bad_index++;
  endtask

  // Pick a request weighted toward growing, shrinking or anything
  function automatic logic [FUNC_W-1:0] pick_func(input mix_mode_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 25) return FUNC_PUSH;
        if (roll < 50) return FUNC_INSERT;
        if (roll < 70) return FUNC_INS_MID;
        if (roll < 85) return FUNC_READ;
        return 3'($urandom_range(0, 7));
      end
      MODE_DRAIN: begin
        if (roll < 25) return FUNC_POP;
        if (roll < 50) return FUNC_REMOVE;
        if (roll < 70) return FUNC_REM_MID;
        if (roll < 85) return FUNC_READ;
        return 3'($urandom_range(0, 7));
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // Mostly legal indices for the current fill, sometimes anything
  function automatic logic [POS_W-1:0] pick_pos(input logic [FUNC_W-1:0] f);
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    if (f == FUNC_INSERT) return 5'($urandom_range(0, shadow_count));
    if (shadow_count == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, shadow_count - 1));
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("Mismatches found");
    $finish;
  end

  // Result side: stall at random, accept a beat, compare with the oldest expectation
  initial begin
    array_result_t       want;
    int unsigned         wait_n;
    logic [COUNT_W-1:0]  got_count;
    logic [ELEM_W-1:0]   got_elem;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      if (rx_long_hold_req) begin
        rx_long_hold_req = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end
      wait_n = draw_gap();
      repeat (wait_n) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got_count = m_axis_tdata[COUNT_W-1:0];
      got_elem  = m_axis_tdata[COUNT_W +: ELEM_W];
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending: status %0d count %0d elem %h",
               m_axis_tuser, got_count, got_elem);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          n_errors++;
        end
        if (got_count !== want.count) begin
          $error("element_count: expected %0d, got %0d", want.count, got_count);
          n_errors++;
        end
        if (got_elem !== want.elem) begin
          $error("element_out: expected %h, got %h", want.elem, got_elem);
          n_errors++;
        end
      end
    end
  end

  // Request side: reset, directed table, then random phases
  initial begin
    mix_mode_e         mode;
    logic [FUNC_W-1:0] f;
    array_result_t     none;
    none             = '{ST_OK, 5'd0, 32'h0};
    n_sent           = 0;
    n_checked        = 0;
    n_errors         = 0;
    n_full           = 0;
    n_empty          = 0;
    n_bad_index      = 0;
    no_idle          = 1'b0;
    rx_long_hold_req = 1'b0;
    shadow_count     = 0;
    for (int i = 0; i < DEPTH; i++) shadow_cells[i] = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tbl[i])
      send_request(directed_tbl[i].func, directed_tbl[i].pos, directed_tbl[i].elem,
                   directed_tbl[i].typed, directed_tbl[i].want);

    mode = MODE_FILL;
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      // Pick a new mix at random every 60 requests
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       mode = MODE_FILL;
          1:       mode = MODE_DRAIN;
          default: mode = MODE_MIX;
        endcase
      end
      // Back-pressure burst: receiver holds off while requests keep coming
      if (n == 300) begin
        rx_long_hold_req = 1'b1;
        no_idle          = 1'b1;
      end
      if (n == 340) no_idle = 1'b0;
      // Drop the offer and let the block drain completely before continuing
      if (n == 700) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      // Stretch with no idling on either side
      if (n == 900)  no_idle = 1'b1;
      if (n == 1000) no_idle = 1'b0;
      f = pick_func(mode);
      send_request(f, pick_pos(f), pick_elem(), 1'b0, none);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d requests (%0d directed), checked %0d result beats",
             n_sent, $size(directed_tbl), n_checked);
    $display("Saw %0d full drops, %0d empty no-ops, %0d bad indices",
             n_full, n_empty, n_bad_index);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
